/* hdl/pstp_pkg.sv */
// Shared types, constants and tables for the polar scan to pixel converter.
package pstp_pkg;

  // Parameter defaults
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned RANGE_BITS_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_LO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PPM         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd6;

  localparam logic [15:0] RST_ANGLE_START = 16'd0;
  localparam logic [15:0] RST_ANGLE_STEP  = 16'd182;
  localparam logic [15:0] RST_GATE_LO     = 16'd120;
  localparam logic [15:0] RST_GATE_HI     = 16'd12000;
  localparam logic [7:0]  RST_PPM         = 8'd50;
  localparam logic [9:0]  RST_CENTER_X    = 10'd250;
  localparam logic [9:0]  RST_CENTER_Y    = 10'd250;

  // CORDIC
  localparam int unsigned CORDIC_ITERS = 16;
  localparam int unsigned ITER_W       = 4;
  localparam int unsigned XY_W         = 18;
  localparam int unsigned Z_W          = 32;
  localparam int unsigned PHASE_W      = 32;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 18'sd19898;

  // Q1.15 trig values and scaling
  localparam int unsigned Q15_W    = 16;
  localparam int unsigned Q15_FRAC = 15;
  localparam int unsigned PPM_W    = 8;

  // Division by 1000 through a reciprocal: exact for dividends below 2^23.
  localparam int unsigned QIN_W       = 23;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned QUO_W       = 14;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 24'd8589935;

  // Pixel output
  localparam int unsigned PIX_W = 13;
  localparam int unsigned SUM_W = 16;
  localparam logic signed [SUM_W-1:0] PIX_MIN = -16'sd4096;
  localparam logic signed [SUM_W-1:0] PIX_MAX = 16'sd4095;

  typedef struct packed {
    logic [15:0] angle_start;
    logic [15:0] angle_step;
    logic [15:0] gate_lo;
    logic [15:0] gate_hi;
    logic [7:0]  ppm;
    logic [9:0]  center_x;
    logic [9:0]  center_y;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic iter;
    logic map;
    logic prod;
    logic quot;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_last;
  } dp_sts_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [Z_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      4'd0:    v = 32'h2000_0000;
      4'd1:    v = 32'h12E4_051E;
      4'd2:    v = 32'h09FB_385B;
      4'd3:    v = 32'h0511_11D4;
      4'd4:    v = 32'h028B_0D43;
      4'd5:    v = 32'h0145_D7E1;
      4'd6:    v = 32'h00A2_F61E;
      4'd7:    v = 32'h0051_7C55;
      4'd8:    v = 32'h0028_BE53;
      4'd9:    v = 32'h0014_5F2F;
      4'd10:   v = 32'h000A_2F98;
      4'd11:   v = 32'h0005_17CC;
      4'd12:   v = 32'h0002_8BE6;
      4'd13:   v = 32'h0001_45F3;
      4'd14:   v = 32'h0000_A2FA;
      default: v = 32'h0000_517D;
    endcase
    return v;
  endfunction

endpackage

/* hdl/pstp_cfg.sv */
// Configuration register file of the polar scan to pixel converter.
module pstp_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [pstp_pkg::CFG_IDX_W-1:0]   wr_index_i,
  input  logic [pstp_pkg::CFG_DATA_W-1:0]  wr_data_i,
  output pstp_pkg::cfg_t                   cfg_o
);

  pstp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_start <= pstp_pkg::RST_ANGLE_START;
      cfg_q.angle_step  <= pstp_pkg::RST_ANGLE_STEP;
      cfg_q.gate_lo     <= pstp_pkg::RST_GATE_LO;
      cfg_q.gate_hi     <= pstp_pkg::RST_GATE_HI;
      cfg_q.ppm         <= pstp_pkg::RST_PPM;
      cfg_q.center_x    <= pstp_pkg::RST_CENTER_X;
      cfg_q.center_y    <= pstp_pkg::RST_CENTER_Y;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        pstp_pkg::REG_ANGLE_START: cfg_q.angle_start <= wr_data_i;
        pstp_pkg::REG_ANGLE_STEP:  cfg_q.angle_step  <= wr_data_i;
        pstp_pkg::REG_GATE_LO:     cfg_q.gate_lo     <= wr_data_i;
        pstp_pkg::REG_GATE_HI:     cfg_q.gate_hi     <= wr_data_i;
        pstp_pkg::REG_PPM:         cfg_q.ppm         <= wr_data_i[7:0];
        pstp_pkg::REG_CENTER_X:    cfg_q.center_x    <= wr_data_i[9:0];
        pstp_pkg::REG_CENTER_Y:    cfg_q.center_y    <= wr_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/pstp_ctrl.sv */
// Sequencing state machine of the polar scan to pixel converter.
module pstp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pstp_pkg::dp_sts_t sts_i,
  output pstp_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORD = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_PROD = 3'd3;
  localparam logic [2:0] S_QUOT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CORD;
        end
      end
      S_CORD: begin
        cmd_o.iter = 1'b1;
        if (sts_i.iter_last) begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_PROD;
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_QUOT;
      end
      S_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts_cordic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_CORD))
    else $error("accepted word did not start the CORDIC");

  a_cordic_runs_to_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD && !sts_i.iter_last) |=> (state_q == S_CORD))
    else $error("CORDIC left before its last iteration");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result appeared without a finishing step");

  a_pending_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && out_stall_i) |=> (state_q == S_FIN))
    else $error("finished word left while output was blocked");

endmodule

/* hdl/pstp_dp.sv */
// Datapath: angle tracking, iterative CORDIC, scaling and pixel saturation.
module pstp_dp #(
  parameter int unsigned ANGLE_BITS = pstp_pkg::ANGLE_BITS_DEF,
  parameter int unsigned RANGE_BITS = pstp_pkg::RANGE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pstp_pkg::cfg_t                      cfg_i,
  input  pstp_pkg::dp_cmd_t                   cmd_i,
  output pstp_pkg::dp_sts_t                   sts_o,
  input  logic [RANGE_BITS-1:0]               range_mm_i,
  input  logic                                last_of_scan_i,
  output logic signed [pstp_pkg::PIX_W-1:0]   pixel_x_o,
  output logic signed [pstp_pkg::PIX_W-1:0]   pixel_y_o,
  output logic                                plotted_o,
  output logic                                scan_done_o
);

  localparam int unsigned KW  = RANGE_BITS + pstp_pkg::PPM_W;
  localparam int unsigned PW  = KW + pstp_pkg::Q15_W;
  localparam int unsigned SW  = (PW > pstp_pkg::QIN_W) ? PW : pstp_pkg::QIN_W + 1;
  localparam int unsigned CW  = (RANGE_BITS > 16) ? RANGE_BITS : 16;
  localparam int unsigned MW  = pstp_pkg::QIN_W + pstp_pkg::RECIP_W;
  localparam int unsigned XE_W = pstp_pkg::XY_W + 1;
  localparam logic [pstp_pkg::QIN_W-1:0] QMAX = {pstp_pkg::QIN_W{1'b1}};

  // ---------------------------------------------------------------- accept
  logic [ANGLE_BITS-1:0]         angle_off_q;
  logic [ANGLE_BITS-1:0]         angle;
  logic [pstp_pkg::PHASE_W-1:0]  phase;
  logic                          hit;
  logic [KW-1:0]                 k_prod;

  logic [KW-1:0]                 k_q;
  logic                          hit_q;
  logic                          last_q;
  logic [1:0]                    quad_q;

  assign angle  = ANGLE_BITS'(cfg_i.angle_start) + angle_off_q;
  assign phase  = {angle, {(pstp_pkg::PHASE_W - ANGLE_BITS){1'b0}}};
  assign hit    = (CW'(range_mm_i) >= CW'(cfg_i.gate_lo)) &&
                  (CW'(range_mm_i) <= CW'(cfg_i.gate_hi));
  assign k_prod = KW'(range_mm_i) * KW'(cfg_i.ppm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_off_q <= '0;
    end else if (cmd_i.load) begin
      // The offset restarts after the last sample of a scan.
      angle_off_q <= last_of_scan_i ? '0 : angle_off_q + ANGLE_BITS'(cfg_i.angle_step);
    end
  end

  // ---------------------------------------------------------------- CORDIC
  logic signed [pstp_pkg::XY_W-1:0] x_q, y_q, dx, dy;
  logic signed [pstp_pkg::Z_W-1:0]  z_q, atan_v;
  logic [pstp_pkg::ITER_W-1:0]      iter_q;

  assign dx     = y_q >>> iter_q;
  assign dy     = x_q >>> iter_q;
  assign atan_v = $signed(pstp_pkg::atan_turn(iter_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q    <= k_prod;
      hit_q  <= hit;
      last_q <= last_of_scan_i;
      quad_q <= phase[pstp_pkg::PHASE_W-1 -: 2];
      x_q    <= pstp_pkg::CORDIC_X0;
      y_q    <= '0;
      z_q    <= $signed({2'b00, phase[pstp_pkg::PHASE_W-3:0]});
      iter_q <= '0;
    end else if (cmd_i.iter) begin
      if (!z_q[pstp_pkg::Z_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end
      iter_q <= iter_q + 1'b1;
    end
  end

  assign sts_o.iter_last = (iter_q == pstp_pkg::ITER_W'(pstp_pkg::CORDIC_ITERS - 1));

  // ---------------------------------------------------------------- quadrant
  function automatic logic signed [pstp_pkg::Q15_W-1:0] clamp_q15(
    input logic signed [XE_W-1:0] v
  );
    logic signed [pstp_pkg::Q15_W-1:0] r;
    if (v > XE_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -XE_W'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = v[pstp_pkg::Q15_W-1:0];
    end
    return r;
  endfunction

  logic signed [XE_W-1:0]            xe, ye, s_w, c_w;
  logic signed [pstp_pkg::Q15_W-1:0] sin_q, cos_q;

  assign xe = {x_q[pstp_pkg::XY_W-1], x_q};
  assign ye = {y_q[pstp_pkg::XY_W-1], y_q};

  always_comb begin
    case (quad_q)
      2'd0:    begin s_w = ye;  c_w = xe;  end
      2'd1:    begin s_w = xe;  c_w = -ye; end
      2'd2:    begin s_w = -ye; c_w = -xe; end
      default: begin s_w = -xe; c_w = ye;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      sin_q <= clamp_q15(s_w);
      cos_q <= clamp_q15(c_w);
    end
  end

  // ---------------------------------------------------------------- scaling
  // Work on magnitudes so that the division truncates toward zero.
  logic [pstp_pkg::Q15_W-1:0] abs_s, abs_c;
  logic [PW-1:0]              prod_x, prod_y;
  logic [SW-1:0]              sh_x, sh_y;
  logic [pstp_pkg::QIN_W-1:0] qx_q, qy_q;
  logic                       neg_x_q, neg_y_q;

  assign abs_s  = sin_q[pstp_pkg::Q15_W-1] ? (~sin_q + 1'b1) : sin_q;
  assign abs_c  = cos_q[pstp_pkg::Q15_W-1] ? (~cos_q + 1'b1) : cos_q;
  assign prod_x = PW'(k_q) * PW'(abs_s);
  assign prod_y = PW'(k_q) * PW'(abs_c);
  assign sh_x   = SW'(prod_x >> pstp_pkg::Q15_FRAC);
  assign sh_y   = SW'(prod_y >> pstp_pkg::Q15_FRAC);

  // A clamped dividend still gives a quotient far past the pixel limits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      qx_q    <= (sh_x > SW'(QMAX)) ? QMAX : sh_x[pstp_pkg::QIN_W-1:0];
      qy_q    <= (sh_y > SW'(QMAX)) ? QMAX : sh_y[pstp_pkg::QIN_W-1:0];
      neg_x_q <= sin_q[pstp_pkg::Q15_W-1];
      neg_y_q <= cos_q[pstp_pkg::Q15_W-1];
    end
  end

  logic [MW-1:0]              mx, my;
  logic [pstp_pkg::QUO_W-1:0] quo_x_q, quo_y_q;

  assign mx = MW'(qx_q) * MW'(pstp_pkg::RECIP_1000);
  assign my = MW'(qy_q) * MW'(pstp_pkg::RECIP_1000);

  always_ff @(posedge clk_i) begin
    if (cmd_i.quot) begin
      quo_x_q <= mx[pstp_pkg::RECIP_SHIFT +: pstp_pkg::QUO_W];
      quo_y_q <= my[pstp_pkg::RECIP_SHIFT +: pstp_pkg::QUO_W];
    end
  end

  // ---------------------------------------------------------------- pixel
  function automatic logic signed [pstp_pkg::PIX_W-1:0] sat_pix(
    input logic signed [pstp_pkg::SUM_W-1:0] v
  );
    logic signed [pstp_pkg::PIX_W-1:0] r;
    if (v > pstp_pkg::PIX_MAX) begin
      r = pstp_pkg::PIX_MAX[pstp_pkg::PIX_W-1:0];
    end else if (v < pstp_pkg::PIX_MIN) begin
      r = pstp_pkg::PIX_MIN[pstp_pkg::PIX_W-1:0];
    end else begin
      r = v[pstp_pkg::PIX_W-1:0];
    end
    return r;
  endfunction

  logic signed [pstp_pkg::SUM_W-1:0] mag_x, mag_y, term_x, term_y, sum_x, sum_y;
  logic signed [pstp_pkg::PIX_W-1:0] px_q, py_q;
  logic                              plotted_q, done_q;

  assign mag_x  = $signed(pstp_pkg::SUM_W'(quo_x_q));
  assign mag_y  = $signed(pstp_pkg::SUM_W'(quo_y_q));
  assign term_x = neg_x_q ? -mag_x : mag_x;
  assign term_y = neg_y_q ? -mag_y : mag_y;
  assign sum_x  = $signed(pstp_pkg::SUM_W'(cfg_i.center_x)) + term_x;
  assign sum_y  = $signed(pstp_pkg::SUM_W'(cfg_i.center_y)) - term_y;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      px_q      <= hit_q ? sat_pix(sum_x) : '0;
      py_q      <= hit_q ? sat_pix(sum_y) : '0;
      plotted_q <= hit_q;
      done_q    <= last_q;
    end
  end

  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign plotted_o   = plotted_q;
  assign scan_done_o = done_q;

endmodule

/* hdl/polar_scan_to_pixel.sv */
// Polar scan to pixel converter: top level joining registers, controller and datapath.
//
// Each word carries one range sample; the block keeps a running binary angle
// (start angle plus step times sample index, restarting after the word marked
// last of scan) and returns one result word per sample: the pixel position of
// the point, saturated to signed 13 bits, or zeros with plotted low when the
// range lies outside the gate. After acceptance a sample passes through 16
// iterations of the iterative CORDIC, which forms sine and cosine one iteration
// a cycle, then quadrant mapping, scaling, division by 1000 and the final add
// and saturate. The block works on one sample at a time and takes the next
// sample while a finished result still waits in the output register.
// Configuration writes are accepted every cycle and must be made while no
// sample is in flight.
module polar_scan_to_pixel #(
  parameter int unsigned ANGLE_BITS = pstp_pkg::ANGLE_BITS_DEF,
  parameter int unsigned RANGE_BITS = pstp_pkg::RANGE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Sample input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [RANGE_BITS-1:0]              range_mm_i,
  input  logic                               last_of_scan_i,
  // Result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pstp_pkg::PIX_W-1:0]  pixel_x_o,
  output logic signed [pstp_pkg::PIX_W-1:0]  pixel_y_o,
  output logic                               plotted_o,
  output logic                               scan_done_o,
  // Configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pstp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pstp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  pstp_pkg::cfg_t    cfg;
  pstp_pkg::dp_cmd_t cmd;
  pstp_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pstp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  pstp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pstp_dp #(
    .ANGLE_BITS (ANGLE_BITS),
    .RANGE_BITS (RANGE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .range_mm_i     (range_mm_i),
    .last_of_scan_i (last_of_scan_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .plotted_o      (plotted_o),
    .scan_done_o    (scan_done_o)
  );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the polar scan to pixel converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  IDLE_PCT        = 18;
  localparam int  SETTLE_CYCLES   = 30;
  localparam int  RAND_PHASES     = 7;
  localparam int  ITEMS_PER_PHASE = 122;
  localparam int  CALM_PHASE      = 3;
  localparam logic [pstp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint Q15_DIV = 64'd32768000;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam longint ATAN_TURN [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct packed {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic               plotted;
    logic               scan_done;
  } pixel_word_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [2:0]         idx;
    logic [15:0]        data;
    logic [15:0]        range_mm;
    logic               last;
    logic               typed;
    pixel_word_t        want;
  } row_t;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall_o;
  logic [15:0]          range_mm     = '0;
  logic                 last_of_scan = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall    = 1'b0;
  logic signed [12:0]   pixel_x_o;
  logic signed [12:0]   pixel_y_o;
  logic                 plotted_o;
  logic                 scan_done_o;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready_o;
  logic [2:0]           cfg_index    = '0;
  logic [15:0]          cfg_data     = '0;

  // Typed expectation travels with the sample word it belongs to.
  logic                 typed_on     = 1'b0;
  pixel_word_t          typed_word   = '0;

  logic                 calm = 1'b0;
  pstp_pkg::cfg_t       plot_cfg;
  logic [15:0]          angle_offset;
  pixel_word_t          pixel_q [$];
  int                   mismatches = 0;
  int                   n_samples  = 0;
  int                   n_plotted  = 0;
  int                   n_scans    = 0;
  int                   n_writes   = 0;

  polar_scan_to_pixel DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .range_mm_i     (range_mm),
    .last_of_scan_i (last_of_scan),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .plotted_o      (plotted_o),
    .scan_done_o    (scan_done_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Sine and cosine in Q1.15 from a 16-step rotation over the low 30 phase bits.
  function automatic void trig_q15(input logic [15:0] ang, output longint s_q, output longint c_q);
    logic [31:0] phase;
    longint      x, y, z, dx, dy, s, c;
    phase = {ang, 16'h0000};
    z = longint'({34'd0, phase[29:0]});
    x = 19898;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end
    end
    case (phase[31:30])
      2'd0:    begin s = y;  c = x;  end
      2'd1:    begin s = x;  c = -y; end
      2'd2:    begin s = -y; c = -x; end
      default: begin s = -x; c = y;  end
    endcase
    s_q = clamp(s, -32768, 32767);
    c_q = clamp(c, -32768, 32767);
  endfunction

  function automatic pixel_word_t predict_pixel(input logic [15:0] rng, input logic last);
    pixel_word_t w;
    longint      k, s, c, px, py;
    w = '0;
    w.scan_done = last;
    w.plotted = (rng >= plot_cfg.gate_lo) && (rng <= plot_cfg.gate_hi);
    if (w.plotted) begin
      trig_q15(plot_cfg.angle_start + angle_offset, s, c);
      k  = longint'(rng) * longint'(plot_cfg.ppm);
      px = clamp(longint'(plot_cfg.center_x) + (k * s) / Q15_DIV, -4096, 4095);
      py = clamp(longint'(plot_cfg.center_y) - (k * c) / Q15_DIV, -4096, 4095);
      w.x = px[12:0];
      w.y = py[12:0];
    end
    angle_offset = last ? 16'd0 : angle_offset + plot_cfg.angle_step;
    return w;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      pstp_pkg::REG_ANGLE_START: plot_cfg.angle_start = data;
      pstp_pkg::REG_ANGLE_STEP:  plot_cfg.angle_step  = data;
      pstp_pkg::REG_GATE_LO:     plot_cfg.gate_lo     = data;
      pstp_pkg::REG_GATE_HI:     plot_cfg.gate_hi     = data;
      pstp_pkg::REG_PPM:         plot_cfg.ppm         = data[7:0];
      pstp_pkg::REG_CENTER_X:    plot_cfg.center_x    = data[9:0];
      pstp_pkg::REG_CENTER_Y:    plot_cfg.center_y    = data[9:0];
      default: ;
    endcase
  endfunction

  initial begin
    plot_cfg.angle_start = 16'd0;
    plot_cfg.angle_step  = 16'd182;
    plot_cfg.gate_lo     = 16'd120;
    plot_cfg.gate_hi     = 16'd12000;
    plot_cfg.ppm         = 8'd50;
    plot_cfg.center_x    = 10'd250;
    plot_cfg.center_y    = 10'd250;
    angle_offset         = 16'd0;
  end

  // Model update and checking, all on pre-edge values.
  always @(posedge clk) begin
    pixel_word_t want, got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready_o) begin
        apply_reg(cfg_index, cfg_data);
        n_writes++;
      end
      if (in_valid && !in_stall_o) begin
        want = predict_pixel(range_mm, last_of_scan);
        if (typed_on) want = typed_word;
        pixel_q.push_back(want);
        n_samples++;
        if (want.plotted) n_plotted++;
        if (last_of_scan) n_scans++;
      end
      if (out_valid_o && !out_stall) begin
        got = '{x: pixel_x_o, y: pixel_y_o, plotted: plotted_o, scan_done: scan_done_o};
        if (pixel_q.size() == 0) begin
          $error("result word with no sample pending: x %0d y %0d", got.x, got.y);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          if (got.x !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, got.x);
            mismatches++;
          end
          if (got.y !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, got.y);
            mismatches++;
          end
          if (got.plotted !== want.plotted) begin
            $error("plotted: expected %0d, got %0d", want.plotted, got.plotted);
            mismatches++;
          end
          if (got.scan_done !== want.scan_done) begin
            $error("scan_done: expected %0d, got %0d", want.scan_done, got.scan_done);
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  function automatic row_t smp(input logic [15:0] r, input logic last);
    row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.range_mm = r;
    row.last = last;
    return row;
  endfunction

  function automatic row_t smp_t(input logic [15:0] r, input logic last,
                                 input logic signed [12:0] x, input logic signed [12:0] y,
                                 input logic plotted);
    row_t row;
    row = smp(r, last);
    row.typed = 1'b1;
    row.want = '{x: x, y: y, plotted: plotted, scan_done: last};
    return row;
  endfunction

  function automatic row_t wr(input logic [2:0] idx, input logic [15:0] data);
    row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic logic [15:0] pick_range();
    if (plot_cfg.gate_lo <= plot_cfg.gate_hi && $urandom_range(0, 99) < 80)
      return 16'($urandom_range(plot_cfg.gate_hi, plot_cfg.gate_lo));
    return 16'($urandom);
  endfunction

  // All tasks below are entered and left at a falling edge.
  task automatic push_sample(input row_t r);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    range_mm     <= r.range_mm;
    last_of_scan <= r.last;
    typed_on     <= r.typed;
    typed_word   <= r.want;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  // Hold off new samples until every pending result word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    row_t plan [$];
    int   left;
    logic [15:0] lo, hi;

    // Default gate and scale first, then extremes, zero scale, empty gate, wrap.
    plan.push_back(smp_t(16'd0, 1'b0, 13'sd0, 13'sd0, 1'b0));
    plan.push_back(smp_t(16'd119, 1'b0, 13'sd0, 13'sd0, 1'b0));
    plan.push_back(smp(16'd120, 1'b0));
    plan.push_back(smp(16'd12000, 1'b0));
    plan.push_back(smp_t(16'd12001, 1'b1, 13'sd0, 13'sd0, 1'b0));
    plan.push_back(smp_t(16'hFFFF, 1'b0, 13'sd0, 13'sd0, 1'b0));
    plan.push_back(wr(pstp_pkg::REG_GATE_LO, 16'd0));
    plan.push_back(wr(pstp_pkg::REG_GATE_HI, 16'hFFFF));
    plan.push_back(wr(pstp_pkg::REG_PPM, 16'd255));
    plan.push_back(wr(pstp_pkg::REG_CENTER_X, 16'd0));
    plan.push_back(wr(pstp_pkg::REG_CENTER_Y, 16'd0));
    plan.push_back(wr(pstp_pkg::REG_ANGLE_START, 16'd0));
    plan.push_back(wr(pstp_pkg::REG_ANGLE_STEP, 16'd16384));
    plan.push_back(smp(16'hFFFF, 1'b0));
    plan.push_back(smp(16'hFFFF, 1'b0));
    plan.push_back(smp(16'hFFFF, 1'b0));
    plan.push_back(smp(16'hFFFF, 1'b1));
    plan.push_back(smp(16'd0, 1'b0));
    // Scale of zero through masking: the point sits on the center.
    plan.push_back(wr(pstp_pkg::REG_PPM, 16'h0100));
    plan.push_back(wr(pstp_pkg::REG_CENTER_X, 16'hFFFF));
    plan.push_back(wr(pstp_pkg::REG_CENTER_Y, 16'hFC00 | 16'd1023));
    plan.push_back(smp_t(16'd5000, 1'b1, 13'sd1023, 13'sd1023, 1'b1));
    plan.push_back(wr(pstp_pkg::REG_GATE_LO, 16'd500));
    plan.push_back(wr(pstp_pkg::REG_GATE_HI, 16'd499));
    plan.push_back(wr(REG_UNUSED, 16'h1234));
    plan.push_back(smp_t(16'd499, 1'b0, 13'sd0, 13'sd0, 1'b0));
    plan.push_back(smp_t(16'd500, 1'b1, 13'sd0, 13'sd0, 1'b0));
    plan.push_back(wr(pstp_pkg::REG_GATE_LO, 16'd120));
    plan.push_back(wr(pstp_pkg::REG_GATE_HI, 16'd12000));
    plan.push_back(wr(pstp_pkg::REG_PPM, 16'd50));
    plan.push_back(wr(pstp_pkg::REG_CENTER_X, 16'd250));
    plan.push_back(wr(pstp_pkg::REG_CENTER_Y, 16'd250));
    plan.push_back(wr(pstp_pkg::REG_ANGLE_START, 16'hFFFF));
    plan.push_back(wr(pstp_pkg::REG_ANGLE_STEP, 16'hFFFF));
    plan.push_back(smp(16'd1000, 1'b0));
    plan.push_back(smp(16'd2000, 1'b0));
    plan.push_back(smp(16'd3000, 1'b0));
    plan.push_back(smp(16'd4000, 1'b1));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        push_sample(plan[i]);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      calm = (ph == CALM_PHASE);
      case (ph)
        0: begin
          write_reg(pstp_pkg::REG_ANGLE_START, 16'hFFFF);
          write_reg(pstp_pkg::REG_ANGLE_STEP, 16'd0);
          write_reg(pstp_pkg::REG_GATE_LO, 16'd0);
          write_reg(pstp_pkg::REG_GATE_HI, 16'hFFFF);
          write_reg(pstp_pkg::REG_PPM, 16'd255);
          write_reg(pstp_pkg::REG_CENTER_X, 16'd1023);
          write_reg(pstp_pkg::REG_CENTER_Y, 16'd0);
        end
        1: begin
          write_reg(pstp_pkg::REG_ANGLE_START, 16'd0);
          write_reg(pstp_pkg::REG_ANGLE_STEP, 16'hFFFF);
          write_reg(pstp_pkg::REG_GATE_LO, 16'd0);
          write_reg(pstp_pkg::REG_GATE_HI, 16'hFFFF);
          write_reg(pstp_pkg::REG_PPM, 16'd1);
          write_reg(pstp_pkg::REG_CENTER_X, 16'd0);
          write_reg(pstp_pkg::REG_CENTER_Y, 16'd1023);
        end
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            lo = 16'($urandom);
            hi = 16'($urandom);
          end else begin
            lo = 16'($urandom_range(0, 4000));
            hi = 16'($urandom_range(4000, 65535));
          end
          write_reg(pstp_pkg::REG_ANGLE_START, 16'($urandom));
          case ($urandom_range(0, 3))
            0:       write_reg(pstp_pkg::REG_ANGLE_STEP, 16'($urandom));
            1:       write_reg(pstp_pkg::REG_ANGLE_STEP, 16'd182);
            2:       write_reg(pstp_pkg::REG_ANGLE_STEP, 16'($urandom_range(1, 64)));
            default: write_reg(pstp_pkg::REG_ANGLE_STEP,
                               16'(16'hFFFF - $urandom_range(0, 64)));
          endcase
          write_reg(pstp_pkg::REG_GATE_LO, lo);
          write_reg(pstp_pkg::REG_GATE_HI, hi);
          write_reg(pstp_pkg::REG_PPM, 16'($urandom));
          write_reg(pstp_pkg::REG_CENTER_X, 16'($urandom));
          write_reg(pstp_pkg::REG_CENTER_Y, 16'($urandom));
          write_reg(REG_UNUSED, 16'($urandom));
        end
      endcase
      // Scans of random length, so the end marker also lands early and often.
      left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (left == 0) left = $urandom_range(1, 48);
        left--;
        push_sample(smp(pick_range(), left == 0));
      end
    end

    calm = 1'b0;
    settle();
    $display("Checked %0d sample words (%0d plotted, %0d scan ends) across %0d register writes,",
             n_samples, n_plotted, n_scans, n_writes);
    $display("including gate edges, empty gate, zero scale, saturation and angle wrap.");
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
